>>> rtl/fork_token_mutex_node_defines.svh
// ----------------------------------------------------------------------------
// fork_token_mutex_node_defines
// Assertion macros used by the fork token mutex node RTL.
// ----------------------------------------------------------------------------
`ifndef FORK_TOKEN_MUTEX_NODE_DEFINES_SVH
`define FORK_TOKEN_MUTEX_NODE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define FTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/ftm_pkg.sv
// ----------------------------------------------------------------------------
// ftm_pkg
// Types and constants of the fork token mutex node.
// ----------------------------------------------------------------------------
package ftm_pkg;

    localparam int OP_W       = 3;
    localparam int PEER_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int TALLY_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INIT       = 3'd0,
        OP_LOCAL_REQ  = 3'd1,
        OP_RELEASE    = 3'd2,
        OP_PEER_REQ   = 3'd3,
        OP_PEER_REPLY = 3'd4,
        OP_PEER_DONE  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_CRIT = 2'd2
    } t_phase;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] NODE_ID_RST    = 4'd1;
    localparam logic [CFG_DATA_W-1:0] PEER_COUNT_RST = 4'd2;
    localparam logic [TALLY_W-1:0]    TALLY_MAX      = 4'hF;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_INIT,
        CELL_MARK,
        CELL_RELEASE,
        CELL_PEER_REQ,
        CELL_PEER_REPLY
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [CFG_DATA_W-1:0] node_id;
        logic [CFG_DATA_W-1:0] peer_count;
        logic [PEER_W-1:0]     peer;
        logic                  give_ok;
        logic                  adv;
    } t_cell_cmd;

    typedef struct packed {
        logic need;
        logic pend;
        logic hit;
        logic gave;
    } t_cell_stat;

    typedef struct packed {
        logic              send_valid;
        logic              send_kind;
        logic [PEER_W-1:0] send_to;
        logic              granted;
        logic              all_done;
        logic              last;
    } t_result;

endpackage

>>> rtl/ftm_if.sv
// ----------------------------------------------------------------------------
// ftm_if
// Valid/ready channels of the fork token mutex node: input, result, config.
// ----------------------------------------------------------------------------
interface ftm_in_if;
    logic                        valid;
    logic                        ready;
    logic [ftm_pkg::OP_W-1:0]    operation;
    logic [ftm_pkg::PEER_W-1:0]  peer;

    modport source (output valid, operation, peer, input ready);
    modport sink   (input valid, operation, peer, output ready);
endinterface

interface ftm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        send_valid;
    logic                        send_kind;
    logic [ftm_pkg::PEER_W-1:0]  send_to;
    logic                        granted;
    logic                        all_done;
    logic                        last;

    modport source (output valid, send_valid, send_kind, send_to, granted, all_done, last,
                    input ready);
    modport sink   (input valid, send_valid, send_kind, send_to, granted, all_done, last,
                    output ready);
endinterface

interface ftm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ftm_pkg::CFG_IDX_W-1:0]   index;
    logic [ftm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ftm_cell.sv
// ----------------------------------------------------------------------------
// ftm_cell
// Per-peer cell: fork, dirty and request token bits, a pending-send bit and
// one stage of the scan chain that walks the row to emit sends in order.
// ----------------------------------------------------------------------------
module ftm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftm_pkg::t_cell_cmd  i_cmd,
    input  logic                i_scan,
    output logic                o_scan,
    output ftm_pkg::t_cell_stat o_stat
);

    localparam int IDX_BITS = $clog2(CELL_IDX + 2);
    localparam int CMP_W    = (IDX_BITS > 4) ? IDX_BITS : 4;

    logic r_fork, r_dirty, r_token, r_pend, r_scan;
    logic n_fork, n_dirty, n_token, n_pend, n_scan;

    logic [CMP_W-1:0] w_idx, w_node, w_count, w_peer;
    logic             w_range, w_in_range, w_sel, w_give;

    assign w_idx      = CMP_W'(CELL_IDX);
    assign w_node     = CMP_W'(i_cmd.node_id);
    assign w_count    = CMP_W'(i_cmd.peer_count);
    assign w_peer     = CMP_W'(i_cmd.peer);
    assign w_range    = (w_idx != '0) && (w_idx < w_count);
    assign w_in_range = w_range && (w_idx != w_node);
    assign w_sel      = w_in_range && (w_idx == w_peer);
    assign w_give     = (i_cmd.op == ftm_pkg::CELL_PEER_REQ) && w_sel && r_fork && r_dirty
                        && i_cmd.give_ok;

    always_comb begin
        n_fork  = r_fork;
        n_dirty = r_dirty;
        n_token = r_token;
        n_pend  = r_pend;
        n_scan  = r_scan;
        case (i_cmd.op)
            ftm_pkg::CELL_INIT: begin
                n_fork  = w_range && (w_node < w_idx);
                n_dirty = w_range && (w_node < w_idx);
                n_token = w_range && (w_node > w_idx);
            end
            ftm_pkg::CELL_MARK: begin
                if (w_in_range && !r_fork && r_token) begin
                    n_pend  = 1'b1;
                    n_token = 1'b0;
                end
            end
            ftm_pkg::CELL_RELEASE: begin
                if (w_in_range) begin
                    n_dirty = 1'b1;
                    if (r_token) begin
                        n_fork = 1'b0;
                        n_pend = 1'b1;
                    end
                end
            end
            ftm_pkg::CELL_PEER_REQ: begin
                if (w_sel) begin
                    n_token = 1'b1;
                end
                if (w_give) begin
                    n_fork  = 1'b0;
                    n_dirty = 1'b0;
                end
            end
            ftm_pkg::CELL_PEER_REPLY: begin
                if (w_sel) begin
                    n_fork  = 1'b1;
                    n_dirty = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.adv) begin
            n_scan = i_scan;
            if (r_scan) begin
                n_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fork  <= 1'b0;
            r_dirty <= 1'b0;
            r_token <= 1'b0;
            r_pend  <= 1'b0;
            r_scan  <= 1'b0;
        end else begin
            r_fork  <= n_fork;
            r_dirty <= n_dirty;
            r_token <= n_token;
            r_pend  <= n_pend;
            r_scan  <= n_scan;
        end
    end

    assign o_scan      = r_scan;
    assign o_stat.need = w_in_range && !r_fork;
    assign o_stat.pend = r_pend;
    assign o_stat.hit  = r_scan && r_pend;
    assign o_stat.gave = w_give;

endmodule

>>> rtl/fork_token_mutex_node.sv
// ----------------------------------------------------------------------------
// fork_token_mutex_node
// Flow: an accepted beat passes S_APPLY, then S_STATUS for a status-only result;
//   a beat evaluated again or answered by a single reply also passes S_EVAL, and
//   a release or sweep walks the cell row in S_SCAN one cell per cycle.
// Throughput: sequential; a new beat is taken only in S_IDLE, after the last
//   result beat is loaded. Output stalls hold the scan in place.
// Reset: synchronous; clears fork/token bits, phase idle, tally zero,
//   node_id 1, peer_count 2.
// ----------------------------------------------------------------------------
`include "fork_token_mutex_node_defines.svh"

module fork_token_mutex_node #(
    parameter int MAX_PEERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ftm_in_if.sink    i_in_beat,
    ftm_out_if.source o_out_beat,
    ftm_cfg_if.sink   i_cfg
);

    localparam int IW = $clog2(MAX_PEERS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_EVAL,
        S_REPLY,
        S_SCAN,
        S_STATUS
    } t_state;

    t_state                              r_state, n_state;
    ftm_pkg::t_phase                     r_phase, n_phase;
    logic [ftm_pkg::TALLY_W-1:0]         r_tally, n_tally;
    logic [ftm_pkg::CFG_DATA_W-1:0]      r_node_id, n_node_id;
    logic [ftm_pkg::CFG_DATA_W-1:0]      r_peer_count, n_peer_count;
    logic [ftm_pkg::OP_W-1:0]            r_op, n_op;
    logic [ftm_pkg::PEER_W-1:0]          r_peer, n_peer;
    logic                                r_gave, n_gave;
    logic                                r_sweep, n_sweep;
    logic                                r_do_scan, n_do_scan;
    logic                                r_kind, n_kind;
    logic                                r_emitted, n_emitted;
    logic [IW-1:0]                       r_scan_idx, n_scan_idx;
    logic                                r_out_valid, n_out_valid;
    ftm_pkg::t_result                    r_out, n_out;

    ftm_pkg::t_cell_cmd                  w_cmd;
    ftm_pkg::t_cell_stat                 w_stat [MAX_PEERS];
    logic [MAX_PEERS:0]                  w_scan_chain;
    logic                                w_scan_in;
    logic [MAX_PEERS-1:0]                w_need, w_pend, w_hit, w_gave;
    logic                                w_out_free, w_is_peer, w_all_forks, w_hit_any;
    logic                                w_granted, w_all_done, w_emit_now;

    genvar g;
    generate
        for (g = 0; g < MAX_PEERS; g++) begin : g_cell
            ftm_cell #(.CELL_IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_scan  (w_scan_chain[g]),
                .o_scan  (w_scan_chain[g+1]),
                .o_stat  (w_stat[g])
            );
            assign w_need[g] = w_stat[g].need;
            assign w_pend[g] = w_stat[g].pend;
            assign w_hit[g]  = w_stat[g].hit;
            assign w_gave[g] = w_stat[g].gave;
        end
    endgenerate

    assign w_scan_chain[0] = w_scan_in;
    assign w_out_free  = !r_out_valid || o_out_beat.ready;
    assign w_all_forks = ~|w_need;
    assign w_hit_any   = |w_hit;
    assign w_granted   = (r_phase == ftm_pkg::PH_CRIT);
    assign w_all_done  = ({1'b0, r_tally} + 5'd2) >= {1'b0, r_peer_count};
    assign w_is_peer   = (r_peer != '0) && (r_peer < r_peer_count) && (r_peer != r_node_id)
                         && (32'(r_peer) < 32'(MAX_PEERS));

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_tally      = r_tally;
        n_node_id    = r_node_id;
        n_peer_count = r_peer_count;
        n_op         = r_op;
        n_peer       = r_peer;
        n_gave       = r_gave;
        n_sweep      = r_sweep;
        n_do_scan    = r_do_scan;
        n_kind       = r_kind;
        n_emitted    = r_emitted;
        n_scan_idx   = r_scan_idx;
        n_out_valid  = r_out_valid && !o_out_beat.ready;
        n_out        = r_out;
        w_emit_now   = 1'b0;

        w_cmd.op         = ftm_pkg::CELL_NOP;
        w_cmd.node_id    = r_node_id;
        w_cmd.peer_count = r_peer_count;
        w_cmd.peer       = r_peer;
        w_cmd.give_ok    = 1'b0;
        w_cmd.adv        = 1'b0;
        w_scan_in        = 1'b0;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                ftm_pkg::CFG_NODE_ID:    n_node_id    = i_cfg.data;
                ftm_pkg::CFG_PEER_COUNT: n_peer_count = i_cfg.data;
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_beat.valid) begin
                    n_op      = i_in_beat.operation;
                    n_peer    = i_in_beat.peer;
                    n_gave    = 1'b0;
                    n_sweep   = 1'b0;
                    n_do_scan = 1'b0;
                    n_emitted = 1'b0;
                    n_state   = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_STATUS;
                case (r_op)
                    ftm_pkg::OP_INIT: begin
                        w_cmd.op = ftm_pkg::CELL_INIT;
                        n_phase  = ftm_pkg::PH_IDLE;
                    end
                    ftm_pkg::OP_LOCAL_REQ: begin
                        if (r_phase != ftm_pkg::PH_CRIT) begin
                            n_phase = ftm_pkg::PH_WAIT;
                            n_sweep = 1'b1;
                            n_state = S_EVAL;
                        end
                    end
                    ftm_pkg::OP_RELEASE: begin
                        w_cmd.op        = ftm_pkg::CELL_RELEASE;
                        w_cmd.adv       = 1'b1;
                        w_scan_in       = 1'b1;
                        n_phase         = ftm_pkg::PH_IDLE;
                        n_kind          = ftm_pkg::KIND_REPLY;
                        n_scan_idx      = '0;
                        n_state         = S_SCAN;
                    end
                    ftm_pkg::OP_PEER_REQ: begin
                        if (w_is_peer) begin
                            w_cmd.op      = ftm_pkg::CELL_PEER_REQ;
                            w_cmd.give_ok = (r_phase != ftm_pkg::PH_CRIT);
                            n_gave        = |w_gave;
                            n_sweep       = (r_phase == ftm_pkg::PH_WAIT);
                            n_state       = S_EVAL;
                        end
                    end
                    ftm_pkg::OP_PEER_REPLY: begin
                        if (w_is_peer) begin
                            w_cmd.op = ftm_pkg::CELL_PEER_REPLY;
                            n_sweep  = (r_phase == ftm_pkg::PH_WAIT);
                            n_state  = S_EVAL;
                        end
                    end
                    ftm_pkg::OP_PEER_DONE: begin
                        if (r_tally != ftm_pkg::TALLY_MAX) begin
                            n_tally = r_tally + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EVAL: begin
                if (r_sweep) begin
                    if (w_all_forks) begin
                        n_phase = ftm_pkg::PH_CRIT;
                    end else begin
                        w_cmd.op  = ftm_pkg::CELL_MARK;
                        n_kind    = ftm_pkg::KIND_REQUEST;
                        n_do_scan = 1'b1;
                    end
                end
                if (r_gave) begin
                    n_state = S_REPLY;
                end else if (r_sweep && !w_all_forks) begin
                    w_cmd.adv       = 1'b1;
                    w_scan_in       = 1'b1;
                    n_scan_idx      = '0;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.send_valid = 1'b1;
                    n_out.send_kind  = ftm_pkg::KIND_REPLY;
                    n_out.send_to    = r_peer;
                    n_out.granted    = w_granted;
                    n_out.all_done   = w_all_done;
                    n_out.last       = ~|w_pend;
                    n_emitted        = 1'b1;
                    if (r_do_scan) begin
                        w_cmd.adv       = 1'b1;
                        w_scan_in       = 1'b1;
                        n_scan_idx      = '0;
                        n_state         = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                w_cmd.adv  = w_hit_any ? w_out_free : 1'b1;
                w_emit_now = w_hit_any && w_out_free;
                if (w_emit_now) begin
                    n_out_valid      = 1'b1;
                    n_out.send_valid = 1'b1;
                    n_out.send_kind  = r_kind;
                    n_out.send_to    = 4'(r_scan_idx);
                    n_out.granted    = w_granted;
                    n_out.all_done   = w_all_done;
                    n_out.last       = ~|(w_pend & ~w_hit);
                    n_emitted        = 1'b1;
                end
                if (w_cmd.adv) begin
                    if (r_scan_idx == IW'(MAX_PEERS - 1)) begin
                        n_state = (r_emitted || w_emit_now) ? S_IDLE : S_STATUS;
                    end else begin
                        n_scan_idx = r_scan_idx + 1'b1;
                    end
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.send_valid = 1'b0;
                    n_out.send_kind  = 1'b0;
                    n_out.send_to    = '0;
                    n_out.granted    = w_granted;
                    n_out.all_done   = w_all_done;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= ftm_pkg::PH_IDLE;
            r_tally      <= '0;
            r_node_id    <= ftm_pkg::NODE_ID_RST;
            r_peer_count <= ftm_pkg::PEER_COUNT_RST;
            r_gave       <= 1'b0;
            r_sweep      <= 1'b0;
            r_do_scan    <= 1'b0;
            r_emitted    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_tally      <= n_tally;
            r_node_id    <= n_node_id;
            r_peer_count <= n_peer_count;
            r_op         <= n_op;
            r_peer       <= n_peer;
            r_gave       <= n_gave;
            r_sweep      <= n_sweep;
            r_do_scan    <= n_do_scan;
            r_kind       <= n_kind;
            r_emitted    <= n_emitted;
            r_scan_idx   <= n_scan_idx;
            r_out_valid  <= n_out_valid;
            r_out        <= n_out;
        end
    end

    assign i_in_beat.ready       = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out_beat.valid      = r_out_valid;
    assign o_out_beat.send_valid = r_out.send_valid;
    assign o_out_beat.send_kind  = r_out.send_kind;
    assign o_out_beat.send_to    = r_out.send_to;
    assign o_out_beat.granted    = r_out.granted;
    assign o_out_beat.all_done   = r_out.all_done;
    assign o_out_beat.last       = r_out.last;

    `FTM_ASSERT_ALWAYS(a_hit_onehot0, i_clk, i_rst_n, $onehot0(w_hit), "scan hits more than one cell")
    `FTM_ASSERT_IMPL(a_scan_onehot, i_clk, i_rst_n, r_state == S_SCAN, $onehot(w_scan_chain[MAX_PEERS:1]), "scan marker lost or duplicated")
    `FTM_ASSERT_IMPL(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, ~|w_pend, "sends left pending at idle")
    `FTM_ASSERT_IMPL(a_req_not_granted, i_clk, i_rst_n, r_out_valid && r_out.send_valid && (r_out.send_kind == ftm_pkg::KIND_REQUEST), !r_out.granted, "request beat while granted")

endmodule
